// ===== rtl/twg_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, key codes, waveform tables and lookup functions for the
// table waveform generator. No dependencies.
package twg_pkg;

    localparam int TBL_DEPTH = 64;
    localparam int IDX_W     = 6;
    localparam int NUM_WAVES = 3;

    // Key bytes (ASCII)
    localparam logic [7:0] KEY_SINE   = 8'h73;  // 's'
    localparam logic [7:0] KEY_TRI    = 8'h74;  // 't'
    localparam logic [7:0] KEY_SQUARE = 8'h63;  // 'c'
    localparam logic [7:0] KEY_RESET  = 8'h72;  // 'r'
    localparam logic [7:0] KEY_FASTER = 8'h2B;  // '+'
    localparam logic [7:0] KEY_SLOWER = 8'h2D;  // '-'

    // Output mode codes
    localparam logic [1:0] WAVE_IDLE   = 2'd0;
    localparam logic [1:0] WAVE_TRI    = 2'd1;
    localparam logic [1:0] WAVE_SINE   = 2'd2;
    localparam logic [1:0] WAVE_SQUARE = 2'd3;

    // Index slots, one per waveform
    localparam logic [1:0] SLOT_TRI    = 2'd0;
    localparam logic [1:0] SLOT_SINE   = 2'd1;
    localparam logic [1:0] SLOT_SQUARE = 2'd2;

    localparam logic [2:0] STEP_FASTEST = 3'd1;
    localparam logic [2:0] STEP_SLOWEST = 3'd5;

    typedef enum logic [3:0] {
        MODE_IDLE   = 4'b0001,
        MODE_TRI    = 4'b0010,
        MODE_SINE   = 4'b0100,
        MODE_SQUARE = 4'b1000
    } wave_mode_t;

    typedef struct packed {
        logic [7:0]  sample;
        logic [15:0] timer_reload;
        logic [1:0]  wave_now;
    } twg_result_t;

    localparam logic [7:0] TRI_ROM [0:TBL_DEPTH-1] = '{
        8'd9,   8'd17,  8'd26,  8'd34,  8'd43,  8'd51,  8'd60,  8'd68,  8'd77,  8'd85,
        8'd94,  8'd102, 8'd111, 8'd119, 8'd128, 8'd136, 8'd145, 8'd153, 8'd162, 8'd170,
        8'd179, 8'd187, 8'd196, 8'd204, 8'd213, 8'd221, 8'd230, 8'd238, 8'd247, 8'd255,
        8'd247, 8'd238, 8'd230, 8'd221, 8'd213, 8'd204, 8'd196, 8'd187, 8'd179, 8'd170,
        8'd162, 8'd153, 8'd145, 8'd136, 8'd128, 8'd119, 8'd111, 8'd102, 8'd94,  8'd86,
        8'd77,  8'd68,  8'd60,  8'd51,  8'd43,  8'd34,  8'd26,  8'd17,  8'd9,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0
    };

    localparam logic [7:0] SINE_ROM [0:TBL_DEPTH-1] = '{
        8'd254, 8'd254, 8'd252, 8'd249, 8'd244, 8'd238, 8'd231, 8'd222, 8'd213, 8'd202,
        8'd191, 8'd179, 8'd167, 8'd154, 8'd141, 8'd127, 8'd114, 8'd101, 8'd88,  8'd76,
        8'd64,  8'd53,  8'd42,  8'd33,  8'd24,  8'd17,  8'd11,  8'd6,   8'd3,   8'd1,
        8'd0,   8'd1,   8'd3,   8'd6,   8'd11,  8'd17,  8'd24,  8'd33,  8'd42,  8'd53,
        8'd64,  8'd76,  8'd88,  8'd101, 8'd114, 8'd128, 8'd141, 8'd154, 8'd167, 8'd179,
        8'd191, 8'd202, 8'd213, 8'd222, 8'd231, 8'd238, 8'd244, 8'd249, 8'd252, 8'd254,
        8'd0,   8'd0,   8'd0,   8'd0
    };

    // Square: low for the first half, high for the second, zeros past point 59
    function automatic logic [7:0] square_point(input logic [IDX_W-1:0] idx);
        logic [7:0] val;
        val = ((idx >= 6'd30) && (idx < 6'd60)) ? 8'd255 : 8'd0;
        return val;
    endfunction

    function automatic logic [15:0] reload_for_step(input logic [2:0] step);
        logic [15:0] val;
        unique case (step)
            3'd1:    val = 16'hF2FB;
            3'd2:    val = 16'hEFB9;
            3'd3:    val = 16'hEA4C;
            3'd4:    val = 16'hDF73;
            default: val = 16'hBEE5;
        endcase
        return val;
    endfunction

    function automatic logic [1:0] mode_code(input wave_mode_t mode);
        logic [1:0] code;
        unique case (mode)
            MODE_TRI:    code = WAVE_TRI;
            MODE_SINE:   code = WAVE_SINE;
            MODE_SQUARE: code = WAVE_SQUARE;
            default:     code = WAVE_IDLE;
        endcase
        return code;
    endfunction

    function automatic logic [1:0] mode_slot(input wave_mode_t mode);
        logic [1:0] slot;
        unique case (mode)
            MODE_SINE:   slot = SLOT_SINE;
            MODE_SQUARE: slot = SLOT_SQUARE;
            default:     slot = SLOT_TRI;
        endcase
        return slot;
    endfunction

    function automatic logic [7:0] table_sample(input wave_mode_t mode,
                                                input logic [IDX_W-1:0] idx);
        logic [7:0] val;
        unique case (mode)
            MODE_TRI:    val = TRI_ROM[idx];
            MODE_SINE:   val = SINE_ROM[idx];
            MODE_SQUARE: val = square_point(idx);
            default:     val = 8'd0;
        endcase
        return val;
    endfunction

endpackage

// ===== rtl/twg_out_skid.sv =====
`timescale 1ns / 1ps
// Output register with one skid entry for result transfers.
// Depends on twg_pkg for the result type.
module twg_out_skid (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  twg_pkg::twg_result_t push_data,
    output logic                space,
    output logic                out_valid,
    input  logic                out_ready,
    output twg_pkg::twg_result_t out_data
);
    import twg_pkg::*;

    logic        out_valid_reg, out_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    twg_result_t out_data_reg, out_data_next;
    twg_result_t skid_data_reg, skid_data_next;
    logic        out_fire;

    assign out_fire  = out_valid_reg && out_ready;
    assign space     = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        priority if (skid_valid_reg)
        begin
            // no push can arrive while the skid entry is held
            if (out_fire)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (out_valid_reg && !out_fire)
        begin
            if (push)
            begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else
        begin
            out_valid_next = push;
            if (push)
            begin
                out_data_next = push_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

// ===== rtl/table_waveform_generator.sv =====
`timescale 1ns / 1ps
// Top level of the table waveform generator: key and tick decoding, mode,
// speed and index registers. Depends on twg_pkg and twg_out_skid.
//
//  Channel  | Direction | Payload
//  ---------+-----------+---------------------------------------------------
//  s_*      | in        | tuser: kind (0 key, 1 tick); tdata: key_code
//  m_*      | out       | tdata: sample, timer_reload; tuser: wave_now
//
// Each accepted transfer is decoded in the cycle it arrives; mode, speed
// step and index registers and the output register or its skid entry all
// load at that edge, so one item per clock is sustained while not stalled.
// s_tready is low only while the skid entry behind the output register is
// occupied, i.e. after a result has been stalled and another has followed.
// Reset: idle mode, speed step 5 (slowest), all three indexes at zero.
// Each sample is meant to follow the potentiometer command byte 0x11,
// which is sent outside this block.
module table_waveform_generator #(
    parameter int TABLE_POINTS = 60
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] key_code
    input  logic        s_tuser,   // [0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] sample, [23:8] timer_reload
    output logic [1:0]  m_tuser    // [1:0] wave_now
);
    import twg_pkg::*;

    wave_mode_t                        wave_mode_reg, wave_mode_next;
    logic [2:0]                        speed_step_reg, speed_step_next;
    logic [NUM_WAVES-1:0][IDX_W-1:0]   point_index_reg, point_index_next;

    logic        in_fire;
    logic        push;
    twg_result_t result;
    twg_result_t out_data;
    logic        out_space;
    logic [1:0]  slot;
    logic [IDX_W-1:0] cur_idx;
    logic [IDX_W:0]   idx_inc;

    assign in_fire  = s_tvalid && s_tready;
    assign s_tready = out_space;

    assign slot    = mode_slot(wave_mode_reg);
    assign cur_idx = point_index_reg[slot];
    assign idx_inc = {1'b0, cur_idx} + (IDX_W+1)'(1);

    // Decode the accepted transfer and work out the next state and result
    always_comb
    begin
        wave_mode_next      = wave_mode_reg;
        speed_step_next     = speed_step_reg;
        point_index_next    = point_index_reg;
        push                = 1'b0;
        result.sample       = 8'd0;
        result.timer_reload = reload_for_step(speed_step_reg);
        result.wave_now     = mode_code(wave_mode_reg);
        if (in_fire)
        begin
            if (s_tuser)
            begin
                // tick: play the current point and advance, wrapping at the end
                if (wave_mode_reg != MODE_IDLE)
                begin
                    push          = 1'b1;
                    result.sample = table_sample(wave_mode_reg, cur_idx);
                    if (idx_inc >= (IDX_W+1)'(TABLE_POINTS))
                    begin
                        point_index_next[slot] = '0;
                    end
                    else
                    begin
                        point_index_next[slot] = idx_inc[IDX_W-1:0];
                    end
                end
            end
            else
            begin
                unique case (s_tdata)
                    KEY_SINE:   wave_mode_next = MODE_SINE;
                    KEY_TRI:    wave_mode_next = MODE_TRI;
                    KEY_SQUARE: wave_mode_next = MODE_SQUARE;
                    KEY_RESET:
                    begin
                        // leave the waveform and send a zero sample once
                        if (wave_mode_reg != MODE_IDLE)
                        begin
                            wave_mode_next  = MODE_IDLE;
                            push            = 1'b1;
                            result.wave_now = WAVE_IDLE;
                        end
                    end
                    KEY_FASTER:
                    begin
                        if (wave_mode_reg != MODE_IDLE && speed_step_reg > STEP_FASTEST)
                        begin
                            speed_step_next = speed_step_reg - 3'd1;
                        end
                    end
                    KEY_SLOWER:
                    begin
                        if (wave_mode_reg != MODE_IDLE && speed_step_reg < STEP_SLOWEST)
                        begin
                            speed_step_next = speed_step_reg + 3'd1;
                        end
                    end
                    default:
                    begin
                        // other keys are dropped
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_mode_reg   <= MODE_IDLE;
            speed_step_reg  <= STEP_SLOWEST;
            point_index_reg <= '0;
        end
        else
        begin
            wave_mode_reg   <= wave_mode_next;
            speed_step_reg  <= speed_step_next;
            point_index_reg <= point_index_next;
        end
    end

    // Result register plus skid entry
    twg_out_skid u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (result),
        .space     (out_space),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = {out_data.timer_reload, out_data.sample};
    assign m_tuser = out_data.wave_now;

    // Speed step never leaves its range
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        speed_step_reg >= STEP_FASTEST && speed_step_reg <= STEP_SLOWEST)
        else $error("speed step out of range");

    // A tick while idle moves no index
    a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && s_tuser && wave_mode_reg == MODE_IDLE |=> $stable(point_index_reg))
        else $error("index moved on idle tick");

    // Leaving a waveform always presents a result next cycle
    a_reset_key: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !s_tuser && s_tdata == KEY_RESET && wave_mode_reg != MODE_IDLE
        |=> m_tvalid)
        else $error("no result after leaving waveform");

    // Input stalls only while a result is waiting
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output");

endmodule
